// ===== src/lss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lss_pkg;

	localparam int DEPTH      = 32;
	localparam int DATA_WIDTH = 32;

	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int EXT_W  = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

	typedef enum logic [1:0] {
		CMD_PUSH   = 2'd0,
		CMD_POP    = 2'd1,
		CMD_DUMP   = 2'd2,
		CMD_SEARCH = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_WALK = 1'b1
	} state_t;

	typedef struct packed {
		cmd_t               command;
		logic signed [31:0] value;
	} in_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] data;
		logic               last;
	} out_t;

	// 32-bit input word to stored width, sign-extended
	function automatic logic [DATA_WIDTH-1:0] to_data(input logic signed [31:0] v);
		logic signed [EXT_W-1:0] t;
		t = EXT_W'(v);
		return t[DATA_WIDTH-1:0];
	endfunction

	// stored word to 32-bit result word
	function automatic logic signed [31:0] to_out(input logic [DATA_WIDTH-1:0] d);
		logic signed [EXT_W-1:0] t;
		t = EXT_W'(signed'(d));
		return t[31:0];
	endfunction

endpackage

`default_nettype wire

// ===== src/lss_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/lifo_stack_with_search.sv =====
`timescale 1ns / 1ps
`default_nettype none

// bounded lifo stack with pop, dump and search. a command transfers at a rising edge with
// start high and busy low; every result shows on result for exactly one cycle with valid
// high and cannot be held off, so the receiver must take it then. push and an empty-stack
// status are answered from the idle state without busy, and pushes are taken back to back.
// pop, dump and search raise busy and walk the memory from the top entry: pop returns that
// entry, dump gives one result per cycle after the first down to the bottom, and search
// ends at the first match from the top. the walk is set by the single read port of the entry
// memory, whose read data is registered and which delivers one entry per cycle. the memory
// needs no clearing after reset: only entries below the fill count are ever read.
module lifo_stack_with_search (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire lss_pkg::in_t  req,
	output logic               valid,
	output lss_pkg::out_t      result
);

	localparam int AW = lss_pkg::ADDR_W;
	localparam int CW = lss_pkg::CNT_W;
	localparam int DW = lss_pkg::DATA_WIDTH;

	// control state
	lss_pkg::state_t state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	lss_pkg::cmd_t   op_q, op_d;
	logic [AW-1:0]   addr_q, addr_d;
	logic            valid_q, valid_d;

	// payload
	logic [DW-1:0]   key_q, key_d;
	lss_pkg::out_t   result_q, result_d;

	// memory port
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic            ram_re;
	logic [AW-1:0]   ram_raddr;
	logic [DW-1:0]   ram_rdata;

	logic            accept;
	logic [CW-1:0]   count_dec;
	logic [AW-1:0]   addr_dec;
	logic            at_bottom;
	logic            hit;

	lss_ram #(
		.WIDTH (DW),
		.DEPTH (lss_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (key_d),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign busy      = (state_q != lss_pkg::ST_IDLE);
	assign accept    = start && !busy;
	assign count_dec = count_q - CW'(1);
	assign addr_dec  = addr_q - AW'(1);
	assign at_bottom = (addr_q == '0);
	// ram_rdata holds the entry at addr_q while walking
	assign hit       = (ram_rdata == key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lss_pkg::ST_IDLE;
			count_q <= '0;
			op_q    <= lss_pkg::CMD_PUSH;
			addr_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			op_q    <= op_d;
			addr_q  <= addr_d;
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q    <= key_d;
		result_q <= result_d;
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		op_d      = op_q;
		addr_d    = addr_q;
		key_d     = key_q;
		valid_d   = 1'b0;
		result_d  = result_q;
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_re    = 1'b0;
		ram_raddr = addr_dec;

		case (state_q)
			lss_pkg::ST_IDLE: begin
				if (accept) begin
					op_d  = req.command;
					key_d = lss_pkg::to_data(req.value);
					valid_d = 1'b1;
					result_d.data = '0;
					result_d.last = 1'b1;
					case (req.command)
						lss_pkg::CMD_PUSH: begin
							if (count_q == CW'(lss_pkg::DEPTH)) begin
								// full: the value is dropped
								result_d.status = lss_pkg::STAT_FULL;
							end else begin
								ram_we   = 1'b1;
								count_d  = count_q + CW'(1);
								result_d.status = lss_pkg::STAT_OK;
							end
						end
						default: begin
							if (count_q == '0) begin
								result_d.status = lss_pkg::STAT_EMPTY;
							end else begin
								// fetch the top entry, results come from the walk
								valid_d   = 1'b0;
								ram_re    = 1'b1;
								ram_raddr = count_dec[AW-1:0];
								addr_d    = count_dec[AW-1:0];
								state_d   = lss_pkg::ST_WALK;
								if (req.command == lss_pkg::CMD_POP) begin
									count_d = count_dec;
								end
							end
						end
					endcase
				end
			end
			lss_pkg::ST_WALK: begin
				case (op_q)
					lss_pkg::CMD_SEARCH: begin
						result_d.last = 1'b1;
						if (hit) begin
							valid_d = 1'b1;
							result_d.status = lss_pkg::STAT_OK;
							result_d.data   = lss_pkg::to_out(key_q);
							state_d = lss_pkg::ST_IDLE;
						end else if (at_bottom) begin
							valid_d = 1'b1;
							result_d.status = lss_pkg::STAT_NOT_FOUND;
							result_d.data   = '0;
							state_d = lss_pkg::ST_IDLE;
						end else begin
							ram_re = 1'b1;
							addr_d = addr_dec;
						end
					end
					lss_pkg::CMD_DUMP: begin
						valid_d = 1'b1;
						result_d.status = lss_pkg::STAT_OK;
						result_d.data   = lss_pkg::to_out(ram_rdata);
						result_d.last   = at_bottom;
						if (at_bottom) begin
							state_d = lss_pkg::ST_IDLE;
						end else begin
							ram_re = 1'b1;
							addr_d = addr_dec;
						end
					end
					default: begin
						// pop: single entry already fetched
						valid_d = 1'b1;
						result_d.status = lss_pkg::STAT_OK;
						result_d.data   = lss_pkg::to_out(ram_rdata);
						result_d.last   = 1'b1;
						state_d = lss_pkg::ST_IDLE;
					end
				endcase
			end
			default: begin
				state_d = lss_pkg::ST_IDLE;
			end
		endcase
	end

	assign valid  = valid_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(lss_pkg::DEPTH))
		else $error("fill count beyond depth");

	a_no_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lss_pkg::ST_WALK) |-> !ram_we)
		else $error("memory write during a walk");

	a_push_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.command == lss_pkg::CMD_PUSH) |=> (valid && result.last))
		else $error("push without a result");

	a_walk_ends_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (valid && result.last))
		else $error("walk ended without a final result");

	a_pop_decrements: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.command == lss_pkg::CMD_POP && count_q != '0)
		|=> (count_q == $past(count_dec)))
		else $error("pop did not remove the top entry");
`endif

endmodule

`default_nettype wire
